>>> sv/rqvg_pkg.sv
// Shared types and constants for the rotated quad vertex generator.
package rqvg_pkg;

    localparam int CordicSteps = 14;
    localparam int TrigW       = 16;   // Q1.14 plus headroom
    localparam int AngW        = 17;   // signed residue angle
    localparam int CoordW      = 24;
    localparam int SizeW       = 23;
    localparam int OneGain     = 9949;

    localparam logic [1:0] MODE_CENTRE = 2'd0;
    localparam logic [1:0] MODE_BL     = 2'd1;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic [SizeW-1:0]         size_x;
        logic [SizeW-1:0]         size_y;
        logic [1:0]               mode;
    } t_quad;

    // Payload walking down the CORDIC chain.
    typedef struct packed {
        logic                    vld;
        logic signed [TrigW-1:0] x;
        logic signed [TrigW-1:0] y;
        logic signed [AngW-1:0]  z;
        t_quad                   quad;
    } t_cell;

    function automatic logic signed [AngW-1:0] atan_lut(input int idx);
        logic signed [AngW-1:0] v;
        case (idx)
            0: v = 17'sd8192;
            1: v = 17'sd4836;
            2: v = 17'sd2555;
            3: v = 17'sd1297;
            4: v = 17'sd651;
            5: v = 17'sd326;
            6: v = 17'sd163;
            7: v = 17'sd81;
            8: v = 17'sd41;
            9: v = 17'sd20;
            10: v = 17'sd10;
            11: v = 17'sd5;
            12: v = 17'sd3;
            13: v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/rqvg_cordic_cell.sv
// One CORDIC micro-rotation cell of the sine/cosine chain.
module rqvg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  rqvg_pkg::t_cell     i_cell,
    output rqvg_pkg::t_cell     o_cell
);

    rqvg_pkg::t_cell r_cell, n_cell;

    // rotate toward zero residue, floor shifts
    always_comb begin
        n_cell = i_cell;
        if (i_cell.z >= 0) begin
            n_cell.x = i_cell.x - (i_cell.y >>> STEP);
            n_cell.y = i_cell.y + (i_cell.x >>> STEP);
            n_cell.z = i_cell.z - rqvg_pkg::atan_lut(STEP);
        end else begin
            n_cell.x = i_cell.x + (i_cell.y >>> STEP);
            n_cell.y = i_cell.y - (i_cell.x >>> STEP);
            n_cell.z = i_cell.z + rqvg_pkg::atan_lut(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

>>> sv/rqvg_vertex.sv
// Multiply, round and corner assembly stages after the CORDIC chain.
module rqvg_vertex (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  rqvg_pkg::t_cell           i_cell,
    output logic                      o_vld,
    output logic [8*rqvg_pkg::CoordW-1:0] o_verts
);
    localparam int CW = rqvg_pkg::CoordW;
    localparam int PW = 40;

    // stage A: four products
    logic                 r_va;
    logic signed [PW-1:0] r_cx, r_sx, r_sy, r_cy;
    rqvg_pkg::t_quad      r_qa;
    // stage B: rounded offsets
    logic                 r_vb;
    logic signed [PW-1:0] r_rx, r_ry, r_tx, r_ty;
    rqvg_pkg::t_quad      r_qb;
    // stage C: saturated vertices
    logic                 r_vc;
    logic [8*CW-1:0]      r_out;

    logic signed [PW-1:0] n_rx, n_ry, n_tx, n_ty;
    logic signed [PW-1:0] px, py, v [8];
    logic [8*CW-1:0]      n_out;
    logic                 bl_mode;

    function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p,
                                                 input logic m);
        logic signed [PW-1:0] r;
        if (m) r = (p + 40'sd8192) >>> 14;
        else   r = (p + 40'sd16384) >>> 15;
        return r;
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [PW-1:0] a);
        logic [CW-1:0] r;
        if (a > 40'sd8388607)       r = 24'h7FFFFF;
        else if (a < -40'sd8388608) r = 24'h800000;
        else                        r = a[CW-1:0];
        return r;
    endfunction

    always_comb begin
        bl_mode = (r_qb.mode == rqvg_pkg::MODE_BL);
        n_rx = rnd(r_cx, r_qa.mode == rqvg_pkg::MODE_BL);
        n_ry = rnd(r_sx, r_qa.mode == rqvg_pkg::MODE_BL);
        n_tx = rnd(-r_sy, r_qa.mode == rqvg_pkg::MODE_BL);
        n_ty = rnd(r_cy, r_qa.mode == rqvg_pkg::MODE_BL);
        px = PW'(r_qb.pos_x);
        py = PW'(r_qb.pos_y);
        if (bl_mode) begin
            v[0] = px;          v[1] = py;
            v[2] = px + r_rx;   v[3] = py + r_ry;
            v[4] = px + r_tx;   v[5] = py + r_ty;
        end else begin
            v[0] = px - r_tx - r_rx; v[1] = py - r_ty - r_ry;
            v[2] = px + r_rx - r_tx; v[3] = py + r_ry - r_ty;
            v[4] = px + r_tx - r_rx; v[5] = py + r_ty - r_ry;
        end
        v[6] = px + r_tx + r_rx;
        v[7] = py + r_ty + r_ry;
        for (int k = 0; k < 8; k++) n_out[k*CW +: CW] = sat(v[k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (i_en) begin
            r_va <= i_cell.vld;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx  <= PW'(i_cell.x) * $signed({1'b0, i_cell.quad.size_x});
            r_sx  <= PW'(i_cell.y) * $signed({1'b0, i_cell.quad.size_x});
            r_sy  <= PW'(i_cell.y) * $signed({1'b0, i_cell.quad.size_y});
            r_cy  <= PW'(i_cell.x) * $signed({1'b0, i_cell.quad.size_y});
            r_qa  <= i_cell.quad;
            r_rx  <= n_rx;
            r_ry  <= n_ry;
            r_tx  <= n_tx;
            r_ty  <= n_ty;
            r_qb  <= r_qa;
            r_out <= n_out;
        end
    end

    assign o_vld   = r_vc;
    assign o_verts = r_out;

endmodule

>>> sv/rotated_quad_vertex_generator_unit.sv
// Top level: rotated quad corner generator, CORDIC cell chain plus vertex stages.
// Pipeline: fold register, 14 CORDIC cells, then 3 math stages.
// Throughput: one quad per cycle; the whole pipe advances when the output
// register is empty or being taken, so set by the single stall enable.
// Reset: synchronous active-low i_rst_n clears all valid flags; payload is not reset.
// Invalid modes pass through the chain and come out as zero vertices with a flag.
module rotated_quad_vertex_generator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: pos_x[23:0], pos_y[47:24], size_x[70:48], size_y[93:71],
    //        turn_angle[109:94], origin_mode[111:110]
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y (24 bits each)
    output logic [191:0] m_axis_tdata,
    // tuser: bad_mode
    output logic         m_axis_tuser
);
    localparam int N = rqvg_pkg::CordicSteps;

    logic            en;
    rqvg_pkg::t_cell n_fold, r_fold;
    rqvg_pkg::t_cell chain [N+1];
    logic            vx_vld;
    logic [191:0]    vx_data;
    logic [1:0]      mode_d [3];
    logic [15:0]     ang;
    logic signed [16:0] z0;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // quadrant fold of the angle
    always_comb begin
        ang = s_axis_tdata[109:94];
        z0  = {ang[15], ang};
        n_fold.vld         = s_axis_tvalid;
        n_fold.quad.pos_x  = s_axis_tdata[23:0];
        n_fold.quad.pos_y  = s_axis_tdata[47:24];
        n_fold.quad.size_x = s_axis_tdata[70:48];
        n_fold.quad.size_y = s_axis_tdata[93:71];
        n_fold.quad.mode   = s_axis_tdata[111:110];
        n_fold.y           = '0;
        n_fold.x           = 16'(rqvg_pkg::OneGain);
        n_fold.z           = z0;
        if (z0 > 17'sd16384) begin
            n_fold.z = z0 - 17'sd32768;
            n_fold.x = -16'(rqvg_pkg::OneGain);
        end else if (z0 < -17'sd16384) begin
            n_fold.z = z0 + 17'sd32768;
            n_fold.x = -16'(rqvg_pkg::OneGain);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold.vld <= 1'b0;
        end else if (en) begin
            r_fold <= n_fold;
        end
    end

    assign chain[0] = r_fold;

    for (genvar g = 0; g < N; g++) begin : g_cell
        rqvg_cordic_cell #(.STEP(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_cell (chain[g]),
            .o_cell (chain[g+1])
        );
    end

    rqvg_vertex u_vertex (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_cell (chain[N]),
        .o_vld  (vx_vld),
        .o_verts(vx_data)
    );

    // mode delay line to qualify the output
    always_ff @(posedge i_clk) begin
        if (en) begin
            mode_d[0] <= chain[N].quad.mode;
            for (int k = 1; k < 3; k++) mode_d[k] <= mode_d[k-1];
        end
    end

    assign m_axis_tvalid = vx_vld;
    assign m_axis_tuser  = mode_d[2][1];
    assign m_axis_tdata  = mode_d[2][1] ? '0 : vx_data;

    // stalled result must hold
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // flagged result carries zero vertices
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("bad mode with nonzero vertices");
    // input taken only when pipe advances
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");

endmodule
